@@ rtl/triggered_trace_history_buffer_defines.svh @@
// Assertion macros shared by the trace buffer modules.
// Each expects clk and arst_n in scope.
`ifndef TRIGGERED_TRACE_HISTORY_BUFFER_DEFINES_SVH
`define TRIGGERED_TRACE_HISTORY_BUFFER_DEFINES_SVH

// Check a property every clock, quiet while in reset.
`define TTHB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define TTHB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tthb_pkg.sv @@
package tthb_pkg;

	// default sizes
	localparam int SOURCES_DEF    = 4;
	localparam int DEPTH_DEF      = 16;
	localparam int EVENT_BITS_DEF = 64;

	// count of active sources, wide enough for the largest source count
	localparam int ACT_W = 5;

	// register indexes
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_HOLDOFF   = 2'd1;
	localparam logic [1:0] REG_SOURCES   = 2'd2;

	// register reset values
	localparam logic [23:0] THRESHOLD_RST = 24'd0;
	localparam logic [9:0]  HOLDOFF_RST   = 10'd60;
	localparam logic [2:0]  SOURCES_RST   = 3'd4;

	// opcodes
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [1:0]  source_id;
		logic [63:0] event_word;
		logic [23:0] frame_time_us;
		logic        external_busy;
	} item_t;

	typedef struct packed {
		logic [1:0]  source_id_out;
		logic [63:0] event_out;
		logic        has_event;
		logic        last;
		logic [31:0] capture_number;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic load;
		logic read;
		logic empty;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fire;
		logic mask_any;
		logic src_last;
		logic more;
	} stat_t;

endpackage

@@ rtl/triggered_trace_history_buffer.sv @@
// Triggered trace history buffer.
// Input: an item is taken at a rising edge with start high and busy low. Event
// appends store a word in the source's circular history; frame ticks test the
// frame time against the trigger level once the holdoff has run out.
// Appends and ticks that do not fire never raise busy. A firing tick raises
// busy and replays every active source's history, oldest word first: the
// controller loads a source, reads its words, each registered in the result
// stage, then loads the next source or ends in the done state, which clears the
// histories. An empty capture goes from load straight to done and yields a
// single empty last word. Replay speed is set by the single read port of the
// history memory. Results: one word per cycle on result while result_strobe is
// high; the receiver cannot stall and must take each word in its cycle.
// Configuration: cfg_we writes cfg_data into register cfg_index. The user must
// write only while idle; the block does not enforce this. Writing the threshold
// starts a fresh session.
// Reset: histories empty, holdoff and capture count zero, block disarmed.
module triggered_trace_history_buffer import tthb_pkg::*; #(
	parameter int SOURCES    = SOURCES_DEF,
	parameter int DEPTH      = DEPTH_DEF,
	parameter int EVENT_BITS = EVENT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        result_strobe,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	tthb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	tthb_datapath #(
		.SOURCES    (SOURCES),
		.DEPTH      (DEPTH),
		.EVENT_BITS (EVENT_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.result        (result)
	);

endmodule

@@ rtl/tthb_ctrl.sv @@
`include "triggered_trace_history_buffer_defines.svh"

module tthb_ctrl import tthb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	// decode commands and next state
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = start;
				if (start && stat.fire) begin
					state_nx = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (stat.mask_any) begin
					cmd.load = 1'b1;
					state_nx = ST_READ;
				end else begin
					cmd.empty = 1'b1;
					state_nx  = ST_DONE;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				if (stat.src_last) begin
					state_nx = stat.more ? ST_LOAD : ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_nx   = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != ST_IDLE);

	`TTHB_ASSERT_NEXT(a_fire_loads, (cmd.accept && stat.fire), (state_q == ST_LOAD), "fire lost")
	`TTHB_ASSERT(a_one_cmd, $onehot0({cmd.accept, cmd.load, cmd.read, cmd.empty, cmd.finish}), "cmd clash")
	`TTHB_ASSERT_NEXT(a_done_idle, (state_q == ST_DONE), (state_q == ST_IDLE), "done stuck")

endmodule

@@ rtl/tthb_datapath.sv @@
`include "triggered_trace_history_buffer_defines.svh"

module tthb_datapath import tthb_pkg::*; #(
	parameter int SOURCES    = SOURCES_DEF,
	parameter int DEPTH      = DEPTH_DEF,
	parameter int EVENT_BITS = EVENT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output logic        result_strobe,
	output result_t     result
);

	localparam int SRC_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int ADDR_W = SRC_W + IDX_W;
	localparam int MEM_N  = 1 << ADDR_W;
	localparam logic [IDX_W:0] DEPTH_C = (IDX_W + 1)'(DEPTH);

	// configuration
	logic [23:0] thr_q;
	logic [9:0]  hold_cfg_q;
	logic [2:0]  use_q;

	// per-source history bookkeeping
	logic [IDX_W-1:0] wp_q   [SOURCES];
	logic [IDX_W:0]   fill_q [SOURCES];

	logic [9:0]  hold_q;
	logic [31:0] cap_q;

	// replay walk
	logic [SOURCES-1:0] mask_q;
	logic [SRC_W-1:0]   rs_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic [IDX_W:0]     cnt_q;

	// result stage
	logic                  valid_s1;
	logic                  has_s1;
	logic                  last_s1;
	logic [1:0]            src_s1;
	logic [EVENT_BITS-1:0] data_s1;

	logic [EVENT_BITS-1:0] mem [MEM_N];

	logic [ACT_W-1:0]   nsrc;
	logic [SRC_W-1:0]   in_src;
	logic [SRC_W-1:0]   low_src;
	logic [SRC_W-1:0]   sel_src;
	logic [IDX_W-1:0]   sel_wp;
	logic [IDX_W:0]     sel_fill;
	logic [IDX_W:0]     first_sum;
	logic [IDX_W-1:0]   first_idx;
	logic [SOURCES-1:0] nonempty;
	logic               armed;
	logic               live;
	logic               append;
	logic               tick;
	logic               fire;
	logic               fill_any;

	// active source count, capped at the built source count
	assign nsrc = (ACT_W'(use_q) > ACT_W'(SOURCES)) ? ACT_W'(SOURCES) : ACT_W'(use_q);

	assign in_src = SRC_W'({{(ACT_W - 2){1'b0}}, item.source_id});
	assign armed  = (thr_q != '0);
	assign live   = cmd.accept && !item.external_busy && armed;
	assign append = live && (item.opcode == OP_APPEND)
		&& ({{(ACT_W - 2){1'b0}}, item.source_id} < nsrc);
	assign tick   = live && (item.opcode == OP_TICK);
	assign fire   = tick && (hold_q == '0) && (item.frame_time_us >= thr_q);

	// find the lowest source still to replay
	always_comb begin
		low_src = '0;
		for (int i = SOURCES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				low_src = SRC_W'(i);
			end
		end
	end

	// mark active sources holding events
	always_comb begin
		fill_any = 1'b0;
		for (int i = 0; i < SOURCES; i++) begin
			nonempty[i] = (ACT_W'(i) < nsrc) && (fill_q[i] != '0);
			fill_any    = fill_any | (fill_q[i] != '0);
		end
	end

	assign sel_src  = cmd.load ? low_src : in_src;
	assign sel_wp   = wp_q[sel_src];
	assign sel_fill = fill_q[sel_src];

	// oldest entry: write pointer minus fill, modulo depth
	assign first_sum = {1'b0, sel_wp} + DEPTH_C - sel_fill;
	assign first_idx = (first_sum >= DEPTH_C) ? IDX_W'(first_sum - DEPTH_C)
		: IDX_W'(first_sum);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= THRESHOLD_RST;
			hold_cfg_q <= HOLDOFF_RST;
			use_q      <= SOURCES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q      <= cfg_data;
				REG_HOLDOFF:   hold_cfg_q <= cfg_data[9:0];
				REG_SOURCES:   use_q      <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// pointers, fill counts, holdoff and capture count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SOURCES; i++) begin
				wp_q[i]   <= '0;
				fill_q[i] <= '0;
			end
			hold_q <= '0;
			cap_q  <= '0;
		end else if (cfg_we && (cfg_index == REG_THRESHOLD)) begin
			for (int i = 0; i < SOURCES; i++) begin
				wp_q[i]   <= '0;
				fill_q[i] <= '0;
			end
			hold_q <= '0;
			cap_q  <= '0;
		end else if (cmd.finish) begin
			for (int i = 0; i < SOURCES; i++) begin
				wp_q[i]   <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			if (append) begin
				wp_q[sel_src] <= (sel_wp == IDX_W'(DEPTH - 1)) ? '0 : sel_wp + 1'b1;
				if (sel_fill != DEPTH_C) begin
					fill_q[sel_src] <= sel_fill + 1'b1;
				end
			end
			// count the holdoff down only while it runs
			if (fire) begin
				hold_q <= hold_cfg_q;
				cap_q  <= cap_q + 32'd1;
			end else if (tick && (hold_q != '0)) begin
				hold_q <= hold_q - 10'd1;
			end
		end
	end

	// replay walk over sources and entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '0;
			rs_q     <= '0;
			rd_idx_q <= '0;
			cnt_q    <= '0;
		end else if (fire) begin
			mask_q <= nonempty;
		end else if (cmd.load) begin
			mask_q   <= mask_q & ~(SOURCES'(1) << low_src);
			rs_q     <= low_src;
			rd_idx_q <= first_idx;
			cnt_q    <= sel_fill;
		end else if (cmd.read) begin
			rd_idx_q <= (rd_idx_q == IDX_W'(DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
			cnt_q    <= cnt_q - 1'b1;
		end
	end

	// history memory: write on append, registered read on replay
	always_ff @(posedge clk) begin
		if (append) begin
			mem[{in_src, sel_wp}] <= item.event_word[EVENT_BITS-1:0];
		end
		if (cmd.read) begin
			data_s1 <= mem[{rs_q, rd_idx_q}];
		end
	end

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			has_s1   <= 1'b0;
			last_s1  <= 1'b0;
			src_s1   <= '0;
		end else begin
			valid_s1 <= cmd.read || cmd.empty;
			has_s1   <= cmd.read;
			last_s1  <= cmd.empty || (stat.src_last && !stat.more);
			src_s1   <= cmd.read ? 2'({{(ACT_W - SRC_W){1'b0}}, rs_q}) : 2'b00;
		end
	end

	assign stat.fire     = fire;
	assign stat.mask_any = (mask_q != '0);
	assign stat.src_last = (cnt_q == (IDX_W + 1)'(1));
	assign stat.more     = (mask_q != '0);

	assign result_strobe         = valid_s1;
	assign result.source_id_out  = src_s1;
	assign result.event_out      = has_s1 ? 64'(data_s1) : 64'd0;
	assign result.has_event      = has_s1;
	assign result.last           = last_s1;
	assign result.capture_number = cap_q;

	`TTHB_ASSERT(a_last_at_finish, (valid_s1 && last_s1) |-> cmd.finish, "last word misplaced")
	`TTHB_ASSERT_NEXT(a_clear_after_finish, cmd.finish, (fill_any == 1'b0), "history not cleared")
	`TTHB_ASSERT(a_read_has_data, cmd.read |-> (cnt_q != '0), "read past fill")

endmodule

@@ dv/triggered_trace_history_buffer_test.sv @@
`timescale 1ns / 1ps

module triggered_trace_history_buffer_test;
	import tthb_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;

	// Predict replayed words from a private copy of the histories and counters.
	class trace_capture_board;
		result_t     pending[$];
		logic [63:0] history[4][16];
		logic [3:0]  wr_ptr[4];
		logic [4:0]  fill[4];
		logic [9:0]  holdoff_left;
		logic [31:0] capture_count;
		logic [23:0] threshold;
		logic [9:0]  holdoff_load;
		logic [2:0]  sources;
		int          errors;
		int          items_taken;
		int          words_checked;
		int          captures;
		int          empty_captures;

		function new();
			threshold      = THRESHOLD_RST;
			holdoff_load   = HOLDOFF_RST;
			sources        = SOURCES_RST;
			holdoff_left   = '0;
			capture_count  = '0;
			errors         = 0;
			items_taken    = 0;
			words_checked  = 0;
			captures       = 0;
			empty_captures = 0;
			clear_histories();
		endfunction

		function void clear_histories();
			for (int s = 0; s < 4; s++) begin
				wr_ptr[s] = '0;
				fill[s]   = '0;
			end
		endfunction

		function void write_reg(logic [1:0] idx, logic [23:0] data);
			case (idx)
				REG_THRESHOLD: begin
					// a new trigger level starts a fresh session
					threshold     = data;
					holdoff_left  = '0;
					capture_count = '0;
					clear_histories();
				end
				REG_HOLDOFF: holdoff_load = data[9:0];
				REG_SOURCES: sources = data[2:0];
				default: ;
			endcase
		endfunction

		function void note_item(item_t it);
			logic [2:0] active;
			logic [3:0] idx;
			result_t    word;
			int         base;
			items_taken++;
			active = (sources > 3'd4) ? 3'd4 : sources;
			if (it.external_busy || threshold == '0)
				return;

			// store the word, overwriting the oldest once full
			if (it.opcode == OP_APPEND) begin
				if ({1'b0, it.source_id} >= active)
					return;
				history[it.source_id][wr_ptr[it.source_id]] = it.event_word;
				wr_ptr[it.source_id] = wr_ptr[it.source_id] + 4'd1;
				if (fill[it.source_id] < 5'd16)
					fill[it.source_id] = fill[it.source_id] + 5'd1;
				return;
			end

			// count the holdoff down before testing the frame time
			if (holdoff_left != '0) begin
				holdoff_left = holdoff_left - 10'd1;
				return;
			end
			if (it.frame_time_us < threshold)
				return;

			holdoff_left  = holdoff_load;
			capture_count = capture_count + 32'd1;
			captures++;
			base = pending.size();

			// replay each active source, oldest word first
			for (int s = 0; s < active; s++) begin
				idx = wr_ptr[s] - fill[s][3:0];
				for (int i = 0; i < fill[s]; i++) begin
					word.source_id_out  = 2'(s);
					word.event_out      = history[s][idx];
					word.has_event      = 1'b1;
					word.last           = 1'b0;
					word.capture_number = capture_count;
					pending.push_back(word);
					idx = idx + 4'd1;
				end
			end

			// mark the final word, or stand in one empty word
			if (pending.size() == base) begin
				word = '0;
				word.last           = 1'b1;
				word.capture_number = capture_count;
				pending.push_back(word);
			end else begin
				word = pending.pop_back();
				word.last = 1'b1;
				pending.push_back(word);
			end
			clear_histories();
		endfunction

		function void report(string name, logic [63:0] want, logic [63:0] got);
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			errors++;
		endfunction

		function void check_word(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word, expected none actual %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			words_checked++;
			if (want.last && !want.has_event)
				empty_captures++;
			if (got.source_id_out !== want.source_id_out)
				report("source_id_out", 64'(want.source_id_out), 64'(got.source_id_out));
			if (got.event_out !== want.event_out)
				report("event_out", want.event_out, got.event_out);
			if (got.has_event !== want.has_event)
				report("has_event", 64'(want.has_event), 64'(got.has_event));
			if (got.last !== want.last)
				report("last", 64'(want.last), 64'(got.last));
			if (got.capture_number !== want.capture_number)
				report("capture_number", 64'(want.capture_number),
					64'(got.capture_number));
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic        busy;
	item_t       item      = '0;
	logic        result_strobe;
	result_t     result;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = REG_THRESHOLD;
	logic [23:0] cfg_data  = '0;
	int          cycles     = 0;
	int          settings   = 0;
	int          burst_left = 0;

	trace_capture_board board = new();

	triggered_trace_history_buffer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result_strobe (result_strobe),
		.result        (result),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// Abort a run that hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timed out after %0d cycles", $time, cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Check every strobed result word.
	always @(posedge clk) begin
		if (arst_n && result_strobe)
			board.check_word(result);
	end

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic item_t make_item(logic op, logic [1:0] src, logic [63:0] ev,
			logic [23:0] ft, logic bsy);
		item_t it;
		it.opcode        = op;
		it.source_id     = src;
		it.event_word    = ev;
		it.frame_time_us = ft;
		it.external_busy = bsy;
		return it;
	endfunction

	// Aim frame times at the trigger edge as well as across the full range.
	function automatic logic [23:0] pick_frame_time(logic [23:0] thr);
		case ($urandom_range(0, 5))
			0: return thr - 24'd1;
			1: return thr;
			2: return 24'hFFFFFF;
			3: return 24'($urandom_range(0, 3));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic item_t rand_append();
		return make_item(OP_APPEND, 2'($urandom_range(0, 3)), rand_word(), 24'($urandom),
			$urandom_range(0, 11) == 0);
	endfunction

	function automatic item_t rand_tick();
		return make_item(OP_TICK, 2'($urandom_range(0, 3)), rand_word(),
			pick_frame_time(board.threshold), $urandom_range(0, 11) == 0);
	endfunction

	// Offer one word and hold it until the block takes it.
	task automatic send(input item_t it);
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_item(it);
	endtask

	// Drop start for a while and put noise on the item bus.
	task automatic pause(input int n);
		start <= 1'b0;
		item  <= 92'({$urandom, $urandom, $urandom});
		repeat (n) @(posedge clk);
	endtask

	// Wait until every predicted word is out and the block is idle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Send in bursts with random gaps, now and then draining completely.
	task automatic send_paced(input item_t it);
		send(it);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if ($urandom_range(0, 15) == 0)
				drain();
			else
				pause($urandom_range(1, 6));
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 16);
		end
	endtask

	// Apply one register setting, then runs of appends closed by ticks.
	task automatic run_setting(input bit new_thr, input logic [23:0] thr,
			input logic [9:0] hold, input logic [2:0] src, input int n_items);
		int sent;
		int appends;
		drain();
		if (new_thr)
			write_reg(REG_THRESHOLD, thr);
		write_reg(REG_HOLDOFF, {14'd0, hold});
		write_reg(REG_SOURCES, {21'd0, src});
		settings++;
		sent = 0;
		while (sent < n_items) begin
			appends = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 8);
			repeat (appends) begin
				send_paced(rand_append());
				sent++;
			end
			repeat ($urandom_range(1, 3)) begin
				send_paced(rand_tick());
				sent++;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disarmed after reset: nothing is stored or fired
		send(make_item(OP_APPEND, 2'd0, '1, 24'd0, 1'b0));
		send(make_item(OP_TICK, 2'd0, '0, 24'hFFFFFF, 1'b0));
		drain();

		write_reg(REG_THRESHOLD, 24'd100);
		write_reg(REG_HOLDOFF, 24'd0);
		write_reg(REG_SOURCES, 24'd4);
		settings++;

		// extremes of the word, a busy drop, below and at the trigger level
		send(make_item(OP_APPEND, 2'd0, '1, 24'hFFFFFF, 1'b0));
		send(make_item(OP_APPEND, 2'd1, '0, 24'd0, 1'b0));
		send(make_item(OP_APPEND, 2'd3, rand_word(), 24'($urandom), 1'b0));
		send(make_item(OP_APPEND, 2'd2, rand_word(), 24'($urandom), 1'b1));
		send(make_item(OP_TICK, 2'd3, '1, 24'd99, 1'b0));
		send(make_item(OP_TICK, 2'd0, '0, 24'hFFFFFF, 1'b1));
		send(make_item(OP_TICK, 2'd0, '0, 24'd100, 1'b0));

		// capture with every history empty
		send(make_item(OP_TICK, 2'd1, rand_word(), 24'hFFFFFF, 1'b0));

		// overfill one history so the oldest word is overwritten
		for (int i = 0; i < 17; i++)
			send(make_item(OP_APPEND, 2'd2, rand_word(), 24'($urandom), 1'b0));
		send(make_item(OP_TICK, 2'd2, rand_word(), 24'd100, 1'b0));

		run_setting(1'b1, 24'($urandom_range(1, 4000)), 10'd0, 3'd3, 10);
		run_setting(1'b1, 24'd1, 10'd1, 3'd2, 10);
		run_setting(1'b1, 24'hFFFFFF, 10'd1023, 3'd4, 10);
		run_setting(1'b1, 24'($urandom_range(1, 24'hFFFFFF)), 10'd3, 3'd7, 10);
		run_setting(1'b0, 24'd0, 10'd2, 3'd1, 10);
		run_setting(1'b1, 24'($urandom_range(1, 5000)), 10'd0, 3'd0, 10);
		run_setting(1'b1, 24'd0, 10'd5, 3'd5, 6);
		run_setting(1'b1, 24'd50, 10'd0, 3'd4, 10);
		drain();

		board.errors += board.pending.size();
		$display("Run covered %0d accepted items under %0d register settings, %0d words checked.",
			board.items_taken, settings, board.words_checked);
		$display("Captures fired: %0d, of which %0d with all histories empty.",
			board.captures, board.empty_captures);
		if (board.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ triggered_trace_history_buffer.f @@
+incdir+rtl
rtl/tthb_pkg.sv
rtl/tthb_ctrl.sv
rtl/tthb_datapath.sv
rtl/triggered_trace_history_buffer.sv
dv/triggered_trace_history_buffer_test.sv
